// ===== hdl/crrsched_pkg.sv =====
// Shared types and constants of the credit round-robin frame scheduler.
package crrsched_pkg;

	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = 5;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_WIN  = 2'd1;

	localparam logic [23:0] MAX_FRAME_RESET = 24'd16384;
	localparam logic [30:0] INIT_WIN_RESET  = 31'd65535;
	localparam logic [31:0] CONN_WIN_RESET  = 32'd65535;
	localparam logic [31:0] WINDOW_MAX      = 32'h7FFF_FFFF;

	typedef enum logic [2:0] {
		MODE_OPEN   = 3'd0,
		MODE_CREDIT = 3'd1,
		MODE_CONN   = 3'd2,
		MODE_PUMP   = 3'd3,
		MODE_CLOSE  = 3'd4
	} mode_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [3:0]  slot;
		logic [30:0] stream_number;
		logic [31:0] body_length;
		logic [30:0] credit;
	} in_item_t;

	typedef struct packed {
		logic        sent;
		logic [30:0] frame_stream;
		logic [23:0] frame_length;
		logic        stream_end;
		logic        last;
	} out_item_t;

	// One slot table entry as kept in the slot memory.
	typedef struct packed {
		logic [30:0] stream;
		logic [31:0] total;
		logic [31:0] done_bytes;
		logic [31:0] window;
	} slot_entry_t;

endpackage

// ===== hdl/crrsched_slot_mem.sv =====
// Slot table memory: one write port, one read port with registered read data.
module crrsched_slot_mem import crrsched_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output slot_entry_t       rd_data,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  slot_entry_t       wr_data
);

	slot_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read data holds between reads; the pump relies on that while it waits.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/credit_round_robin_frame_scheduler.sv =====
// Credit round-robin frame scheduler: stream table, credit bookkeeping and pump sequencer.
//
// Use: items arrive on the in channel (in_valid, in_stall, in_data) and are taken at an
// edge where in_valid is high and in_stall is low. Open, close and connection credit items
// complete when taken; a stream credit item for a live slot reads the slot entry when taken
// and writes it back with the credit added in the credit state.
// A pump walks all MAX_STREAMS slots from the rotating cursor, one slot read per cycle from
// the slot memory while the pipeline is not frozen. With a receiver that keeps up, its final
// beat is registered once the last slot read has left stage 2, together with the return to idle.
// Each pump yields one to sixteen result beats on the out channel (out_valid, out_stall,
// out_data); the final beat of a pump carries last, and an empty pump yields one beat with
// sent low. A frame is held back one step so that last can be set on the true final beat.
// While out_stall is high the output register holds its beat; the pump pipeline freezes
// only when it has a new frame and nowhere to put the held one. Items are taken one at a
// time: in_stall is high while a credit or pump item is in progress.
// Registers are written on the cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data),
// which is always ready; index 0 is the maximum frame size, index 1 the initial window.
// Reset clears all slot live and failed flags, sets the connection credit to 65535 and the
// cursor to zero, and loads the register defaults. The slot memory is not cleared; an
// entry's contents are only used after an open has written it.
module credit_round_robin_frame_scheduler import crrsched_pkg::*; #(
	parameter int MAX_STREAMS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	localparam int SW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
	localparam int IW = SW + 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CRED = 3'b010,
		ST_PUMP = 3'b100
	} state_t;

	function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [30:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {2'b00, b};
		return (s > {1'b0, WINDOW_MAX}) ? WINDOW_MAX : s[31:0];
	endfunction

	state_t           st_q;
	logic [23:0]      mfs_q;
	logic [30:0]      init_win_q;
	logic [31:0]      conn_q;
	logic [SW-1:0]    cursor_q;
	logic [IW-1:0]    i_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MAX_STREAMS-1:0] live_q;
	logic [MAX_STREAMS-1:0] failed_q;
	logic [SW-1:0]    cred_slot_q;
	logic [30:0]      cred_amt_q;

	logic             v_s1;
	logic             live_s1;
	logic [SW-1:0]    slot_s1;
	logic             v_s2;
	logic             elig_s2;
	logic [31:0]      a_s2;
	logic [31:0]      rem_s2;
	slot_entry_t      ent_s2;
	logic [SW-1:0]    slot_s2;

	logic             pend_v_q;
	out_item_t        pend_q;
	logic             out_v_q;
	out_item_t        out_q;

	logic             in_acc;
	logic [SW-1:0]    slot_in;
	logic             slot_ok;
	logic             cred_go;
	logic             rd_en;
	logic [SW-1:0]    rd_addr;
	slot_entry_t      rd_data;
	logic             wr_en;
	logic [SW-1:0]    wr_addr;
	slot_entry_t      wr_data;
	logic [IW-1:0]    k_sum;
	logic [SW-1:0]    k_iss;
	logic             issue;
	logic             adv;
	logic             hold;
	logic             out_free;
	logic [32:0]      diff1;
	logic [31:0]      rem1;
	logic             elig1;
	logic [31:0]      a1;
	logic [31:0]      m2;
	logic [31:0]      len2;
	logic             fire2;
	logic             push_pend;
	logic             pump_end;
	logic             push_final;
	out_item_t        frame2;
	out_item_t        final_item;

	assign cfg_ready = 1'b1;
	assign in_stall  = (st_q != ST_IDLE);
	assign in_acc    = in_valid & ~in_stall;
	assign slot_in   = SW'(in_data.slot);
	assign slot_ok   = (32'(in_data.slot) < MAX_STREAMS);
	assign cred_go   = in_acc && (in_data.mode == MODE_CREDIT) && slot_ok && live_q[slot_in];

	// Slot visited by the next issue: cursor plus offset, wrapped once.
	assign k_sum = {1'b0, cursor_q} + {1'b0, i_q[SW-1:0]};
	assign k_iss = (k_sum >= IW'(MAX_STREAMS)) ? SW'(k_sum - IW'(MAX_STREAMS)) : SW'(k_sum);

	assign out_free = ~out_v_q | ~out_stall;

	// Stage 1: slot-local limit from the entry just read.
	assign diff1 = {1'b0, rd_data.total} - {1'b0, rd_data.done_bytes};
	assign rem1  = diff1[31:0];
	assign elig1 = live_s1 & ~diff1[32] & (rem1 != 32'd0);
	assign a1    = (rem1 < rd_data.window) ? rem1 : rd_data.window;

	// Stage 2: apply connection credit, frame size limit and the per-pump result limit.
	assign m2    = (a_s2 < conn_q) ? a_s2 : conn_q;
	assign len2  = (m2 < {8'd0, mfs_q}) ? m2 : {8'd0, mfs_q};
	assign fire2 = v_s2 & elig_s2 & (len2 != 32'd0) & (cnt_q < CNT_W'(MAX_RESULTS));

	assign hold      = fire2 & pend_v_q & ~out_free;
	assign adv       = ~hold;
	assign push_pend = fire2 & pend_v_q & out_free;
	assign issue     = (st_q == ST_PUMP) && (i_q < IW'(MAX_STREAMS)) && adv;
	assign pump_end  = (st_q == ST_PUMP) && (i_q == IW'(MAX_STREAMS)) && !v_s1 && !v_s2;
	assign push_final = pump_end & out_free;

	always_comb begin
		frame2.sent         = 1'b1;
		frame2.frame_stream = ent_s2.stream;
		frame2.frame_length = len2[23:0];
		frame2.stream_end   = (len2 == rem_s2);
		frame2.last         = 1'b0;
		if (pend_v_q) begin
			final_item      = pend_q;
			final_item.last = 1'b1;
		end else begin
			final_item      = '0;
			final_item.last = 1'b1;
		end
	end

	assign rd_en   = issue | cred_go;
	assign rd_addr = issue ? k_iss : slot_in;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = slot_s2;
		wr_data = ent_s2;
		priority if (fire2 && adv) begin
			wr_en              = 1'b1;
			wr_data.done_bytes = ent_s2.done_bytes + len2;
			wr_data.window     = ent_s2.window - len2;
		end else if (st_q == ST_CRED) begin
			wr_en          = 1'b1;
			wr_addr        = cred_slot_q;
			wr_data        = rd_data;
			wr_data.window = add_sat(rd_data.window, cred_amt_q);
		end else if (in_acc && (in_data.mode == MODE_OPEN) && slot_ok) begin
			wr_en              = 1'b1;
			wr_addr            = slot_in;
			wr_data.stream     = in_data.stream_number;
			wr_data.total      = in_data.body_length;
			wr_data.done_bytes = 32'd0;
			wr_data.window     = {1'b0, init_win_q};
		end
	end

	crrsched_slot_mem #(
		.DEPTH (MAX_STREAMS),
		.AW    (SW)
	) u_slot_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mfs_q      <= MAX_FRAME_RESET;
			init_win_q <= INIT_WIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_MAX_FRAME) begin
				mfs_q <= cfg_data[23:0];
			end
			if (cfg_index == CFG_INIT_WIN) begin
				init_win_q <= cfg_data[30:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			conn_q   <= CONN_WIN_RESET;
			cursor_q <= '0;
			i_q      <= '0;
			cnt_q    <= '0;
			live_q   <= '0;
			failed_q <= '0;
			pend_v_q <= 1'b0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						unique case (in_data.mode)
							MODE_OPEN: begin
								if (slot_ok) begin
									live_q[slot_in]   <= 1'b1;
									failed_q[slot_in] <= 1'b0;
								end
							end
							MODE_CREDIT: begin
								if (cred_go) begin
									st_q <= ST_CRED;
								end
							end
							MODE_CONN: begin
								conn_q <= add_sat(conn_q, in_data.credit);
							end
							MODE_PUMP: begin
								st_q  <= ST_PUMP;
								i_q   <= '0;
								cnt_q <= '0;
							end
							MODE_CLOSE: begin
								if (slot_ok) begin
									live_q[slot_in]   <= 1'b0;
									failed_q[slot_in] <= 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_CRED: begin
					st_q <= ST_IDLE;
				end
				ST_PUMP: begin
					if (push_final) begin
						pend_v_q <= 1'b0;
						cursor_q <= (32'(cursor_q) == MAX_STREAMS - 1) ? '0 : cursor_q + 1'b1;
						st_q     <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase

			if (adv) begin
				v_s1 <= issue;
				v_s2 <= v_s1;
			end
			if (issue) begin
				i_q <= i_q + 1'b1;
			end
			if (fire2 && adv) begin
				conn_q   <= conn_q - len2;
				cnt_q    <= cnt_q + 1'b1;
				pend_v_q <= 1'b1;
			end
		end
	end

	// Pump pipeline payload and the latched credit item; only the valids need a reset.
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && in_acc) begin
			cred_slot_q <= slot_in;
			cred_amt_q  <= in_data.credit;
		end
		if (adv) begin
			if (issue) begin
				slot_s1 <= k_iss;
				live_s1 <= live_q[k_iss] & ~failed_q[k_iss];
			end
			elig_s2 <= elig1;
			a_s2    <= a1;
			rem_s2  <= rem1;
			ent_s2  <= rd_data;
			slot_s2 <= slot_s1;
		end
		if (fire2 && adv) begin
			pend_q <= frame2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (push_pend || push_final) begin
			out_v_q <= 1'b1;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_pend) begin
			out_q <= pend_q;
		end else if (push_final) begin
			out_q <= final_item;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

	// The write-back of one slot never meets a read of the same slot.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> (rd_addr != wr_addr))
		else $error("slot memory read and write hit the same entry");

	// A held frame exists only inside a pump.
	a_pend_in_pump: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> (st_q == ST_PUMP))
		else $error("held frame outside a pump");

	// No more frames per pump than the result limit.
	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RESULTS))
		else $error("frame count above limit");

	// While the pipeline is frozen no new slot read is issued.
	a_hold_no_issue: assert property (@(posedge clk) disable iff (!arst_n)
		hold |-> !rd_en)
		else $error("slot read issued while pipeline frozen");

endmodule

// ===== tb/sv/tb_credit_round_robin_frame_scheduler.sv =====
// Self-checking testbench for the credit round-robin frame scheduler.
module tb_credit_round_robin_frame_scheduler;
	import crrsched_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_SLOTS     = 16;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 70;
	localparam int SETTLE_CYCLES = 40;
	localparam int DRAIN_LIMIT   = 40000;
	localparam int CYCLE_LIMIT   = 400000;

	localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
	localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

	// Raw register words per phase; some carry bits above the register width on purpose.
	localparam logic [31:0] FRAME_SIZE_SET [RANDOM_PHASES] = '{
		32'h00FF_FFFF, 32'hFF00_4000, 32'h0000_0001,
		32'h0100_0000, 32'h0000_05DC, 32'h0000_4000
	};
	localparam logic [31:0] INIT_WINDOW_SET [RANDOM_PHASES] = '{
		32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_012C,
		32'h0000_FFFF, 32'h0000_1388, 32'h0000_FFFF
	};

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	in_item_t             in_data   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data  = '0;

	credit_round_robin_frame_scheduler #(
		.MAX_STREAMS(NUM_SLOTS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Scheduler state as predicted by the testbench.
	logic        tbl_live       [NUM_SLOTS];
	logic        tbl_failed     [NUM_SLOTS];
	logic [30:0] tbl_stream     [NUM_SLOTS];
	logic [31:0] tbl_total      [NUM_SLOTS];
	logic [31:0] tbl_sent_bytes [NUM_SLOTS];
	logic [31:0] tbl_window     [NUM_SLOTS];
	logic [31:0] conn_window;
	int          cursor;
	logic [23:0] cur_max_frame;
	logic [30:0] cur_init_window;

	in_item_t  pending_items   [$];
	out_item_t expected_frames [$];
	out_item_t want_frame;

	int queued_cnt     = 0;
	int accepted_cnt   = 0;
	int beat_cnt       = 0;
	int err_cnt        = 0;
	int cycle_cnt      = 0;
	int send_idle_pct  = 8;
	int recv_stall_pct = 70;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report(input string msg);
		$display("MISMATCH: %s", msg);
		err_cnt++;
	endtask

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [30:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {2'b00, b};
		return (s > {1'b0, WINDOW_MAX}) ? WINDOW_MAX : s[31:0];
	endfunction

	// Applies one accepted item to the predicted table and queues the frames it causes.
	task automatic advance_scheduler(input in_item_t it);
		logic [31:0] len;
		int          k;
		int          count;
		logic        have_held;
		out_item_t   held;
		count = 0;
		have_held = 1'b0;
		held = '0;
		case (it.mode)
			MODE_OPEN: begin
				tbl_live[it.slot] = 1'b1;
				tbl_failed[it.slot] = 1'b0;
				tbl_stream[it.slot] = it.stream_number;
				tbl_total[it.slot] = it.body_length;
				tbl_sent_bytes[it.slot] = '0;
				tbl_window[it.slot] = {1'b0, cur_init_window};
			end
			MODE_CREDIT: begin
				if (tbl_live[it.slot])
					tbl_window[it.slot] = sat_add(tbl_window[it.slot], it.credit);
			end
			MODE_CONN: begin
				conn_window = sat_add(conn_window, it.credit);
			end
			MODE_CLOSE: begin
				tbl_live[it.slot] = 1'b0;
				tbl_failed[it.slot] = 1'b1;
			end
			MODE_PUMP: begin
				for (int i = 0; i < NUM_SLOTS && count < MAX_RESULTS; i++) begin
					k = (cursor + i) % NUM_SLOTS;
					if (tbl_live[k] && !tbl_failed[k] && tbl_sent_bytes[k] < tbl_total[k]) begin
						len = tbl_total[k] - tbl_sent_bytes[k];
						if (tbl_window[k] < len)
							len = tbl_window[k];
						if (conn_window < len)
							len = conn_window;
						if ({8'd0, cur_max_frame} < len)
							len = {8'd0, cur_max_frame};
						if (len != 0) begin
							tbl_sent_bytes[k] = tbl_sent_bytes[k] + len;
							tbl_window[k] = tbl_window[k] - len;
							conn_window = conn_window - len;
							// Hold each frame one step so the final one can carry last.
							if (have_held)
								expected_frames = {expected_frames, held};
							held.sent = 1'b1;
							held.frame_stream = tbl_stream[k];
							held.frame_length = len[23:0];
							held.stream_end = (tbl_sent_bytes[k] == tbl_total[k]);
							held.last = 1'b0;
							have_held = 1'b1;
							count++;
						end
					end
				end
				cursor = (cursor + 1) % NUM_SLOTS;
				if (!have_held)
					held = '0;
				held.last = 1'b1;
				expected_frames = {expected_frames, held};
			end
			default: begin
			end
		endcase
	endtask

	function automatic in_item_t make_item(input logic [2:0] mode, input logic [3:0] slot,
			input logic [30:0] num, input logic [31:0] blen, input logic [30:0] cred);
		in_item_t it;
		it.mode = mode;
		it.slot = slot;
		it.stream_number = num;
		it.body_length = blen;
		it.credit = cred;
		return it;
	endfunction

	// Mostly well-formed traffic: opens, credits and pumps, with closes and unknown modes mixed in.
	function automatic in_item_t random_item();
		in_item_t it;
		int       pick;
		it.slot = 4'($urandom);
		it.stream_number = 31'($urandom);
		case ($urandom_range(0, 9))
			0: it.body_length = '0;
			1, 2, 3, 4, 5: it.body_length = $urandom_range(1, 3000);
			6, 7, 8: it.body_length = $urandom_range(1, 200000);
			default: it.body_length = $urandom;
		endcase
		case ($urandom_range(0, 9))
			0: it.credit = '0;
			1, 2, 3, 4, 5: it.credit = 31'($urandom_range(1, 20000));
			6, 7: it.credit = 31'($urandom);
			default: it.credit = WINDOW_MAX[30:0];
		endcase
		pick = $urandom_range(0, 99);
		if (pick < 20)
			it.mode = MODE_OPEN;
		else if (pick < 35)
			it.mode = MODE_CREDIT;
		else if (pick < 50)
			it.mode = MODE_CONN;
		else if (pick < 88)
			it.mode = MODE_PUMP;
		else if (pick < 96)
			it.mode = MODE_CLOSE;
		else
			it.mode = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
		return it;
	endfunction

	task automatic queue_item(input in_item_t it);
		pending_items = {pending_items, it};
		queued_cnt++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_MAX_FRAME: cur_max_frame = val[23:0];
			CFG_INIT_WIN: cur_init_window = val[30:0];
			default: begin
			end
		endcase
	endtask

	task automatic wait_idle();
		int n;
		n = 0;
		while ((accepted_cnt != queued_cnt || expected_frames.size() != 0) && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		// Items without results may still be in flight inside the block.
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Input driver: predicts each accepted beat, then offers the next pending item.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				advance_scheduler(in_data);
				accepted_cnt++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= pending_items.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: checks each accepted result beat against the oldest expectation.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_frames.size() == 0) begin
					report($sformatf("beat %0d: unexpected result %h", beat_cnt, out_data));
				end else begin
					want_frame = expected_frames.pop_front();
					if (out_data.sent !== want_frame.sent)
						report($sformatf("beat %0d: sent got %0d want %0d",
							beat_cnt, out_data.sent, want_frame.sent));
					if (out_data.frame_stream !== want_frame.frame_stream)
						report($sformatf("beat %0d: frame_stream got %0d want %0d",
							beat_cnt, out_data.frame_stream, want_frame.frame_stream));
					if (out_data.frame_length !== want_frame.frame_length)
						report($sformatf("beat %0d: frame_length got %0d want %0d",
							beat_cnt, out_data.frame_length, want_frame.frame_length));
					if (out_data.stream_end !== want_frame.stream_end)
						report($sformatf("beat %0d: stream_end got %0d want %0d",
							beat_cnt, out_data.stream_end, want_frame.stream_end));
					if (out_data.last !== want_frame.last)
						report($sformatf("beat %0d: last got %0d want %0d",
							beat_cnt, out_data.last, want_frame.last));
				end
				beat_cnt++;
			end
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			tbl_live[i] = 1'b0;
			tbl_failed[i] = 1'b0;
			tbl_stream[i] = '0;
			tbl_total[i] = '0;
			tbl_sent_bytes[i] = '0;
			tbl_window[i] = '0;
		end
		conn_window = CONN_WIN_RESET;
		cursor = 0;
		cur_max_frame = MAX_FRAME_RESET;
		cur_init_window = INIT_WIN_RESET;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset register values.
		queue_item(make_item(MODE_PUMP, 4'd0, '0, '0, '0));
		for (int m = MODE_UNUSED_LO; m <= MODE_UNUSED_HI; m++)
			queue_item(make_item(3'(m), 4'd1, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF));
		queue_item(make_item(MODE_CLOSE, 4'd3, '0, '0, '0));
		queue_item(make_item(MODE_OPEN, 4'd0, 31'h7FFF_FFFF, 32'hFFFF_FFFF, '0));
		queue_item(make_item(MODE_OPEN, 4'd15, '0, '0, '0));
		queue_item(make_item(MODE_OPEN, 4'd1, 31'd5, 32'd100, '0));
		queue_item(make_item(MODE_OPEN, 4'd2, 31'd9, 32'd50, '0));
		queue_item(make_item(MODE_CLOSE, 4'd2, '0, '0, '0));
		queue_item(make_item(MODE_CREDIT, 4'd2, '0, '0, 31'd1000));
		// These pumps drain the connection credit until a pump moves nothing.
		repeat (5) queue_item(make_item(MODE_PUMP, 4'd0, '0, '0, '0));
		queue_item(make_item(MODE_CONN, 4'd0, '0, '0, 31'h7FFF_FFFF));
		queue_item(make_item(MODE_CONN, 4'd0, '0, '0, 31'h7FFF_FFFF));
		queue_item(make_item(MODE_CREDIT, 4'd0, '0, '0, 31'h7FFF_FFFF));
		queue_item(make_item(MODE_CREDIT, 4'd0, '0, '0, '0));
		queue_item(make_item(MODE_OPEN, 4'd2, 31'd9, 32'd20000, '0));
		queue_item(make_item(MODE_PUMP, 4'd0, '0, '0, '0));
		queue_item(make_item(MODE_CLOSE, 4'd0, '0, '0, '0));
		queue_item(make_item(MODE_PUMP, 4'd0, '0, '0, '0));

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_idle();
			if (p == RANDOM_PHASES - 1) begin
				write_reg(CFG_SPARE_2, $urandom);
				write_reg(CFG_SPARE_3, $urandom);
			end
			write_reg(CFG_MAX_FRAME, FRAME_SIZE_SET[p]);
			write_reg(CFG_INIT_WIN, INIT_WINDOW_SET[p]);
			send_idle_pct = (p < 2) ? 8 : (p < 4) ? 70 : 0;
			recv_stall_pct = (p < 2) ? 70 : (p < 4) ? 8 : 0;
			for (int n = 0; n < PHASE_ITEMS; n++)
				queue_item(random_item());
		end

		wait_idle();
		if (accepted_cnt != queued_cnt)
			report($sformatf("%0d items never accepted", queued_cnt - accepted_cnt));
		if (expected_frames.size() != 0)
			report($sformatf("%0d expected results never arrived", expected_frames.size()));
		if (err_cnt == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
